>>> design/bucket_mean_accumulator_macros.svh
// assertion macros for the bucket mean accumulator
`ifndef BUCKET_MEAN_ACCUMULATOR_MACROS_SVH
`define BUCKET_MEAN_ACCUMULATOR_MACROS_SVH

// condition implies consequence in the same cycle
`define BMA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define BMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bma_pkg.sv
// shared constants of the bucket mean accumulator
`default_nettype none
package bma_pkg;

  // fixed field widths
  localparam int BUCKET_W = 12;
  localparam int SAMPLE_W = 16;
  localparam int MEAN_W   = 17;
  localparam int STATUS_W = 2;
  localparam int FS_W     = 16;
  localparam int BIU_W    = 13;
  localparam int CFG_W    = 16;

  // request codes
  localparam logic REQ_ACC   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // register indexes
  localparam logic CFG_FULL_SCALE = 1'b0;
  localparam logic CFG_BUCKETS    = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd3;

  // register reset values
  localparam logic [FS_W-1:0]  FS_RESET  = 16'hFFFF;
  localparam logic [BIU_W-1:0] BIU_RESET = 13'd4096;

  // 1.0 in q1.16 and the divider step count (saturation check plus 17 bits)
  localparam logic [MEAN_W-1:0] ONE_Q16  = 17'h10000;
  localparam int                DIV_LAST = 17;
  localparam int                STEP_W   = 5;

endpackage
`default_nettype wire

>>> design/bucket_mean_accumulator.sv
// accumulate, out-of-range and empty items give out_valid after the read state and the result state
// a non-empty query goes through the read state, 18 divider steps and the result state
// one item at a time; in_stall stays high until the result is loaded into the output registers
// the shared divider sets the query time; a mean of two full scales or more ends the divide after its first step
// reset: synchronous active low; the sum/count ram is then cleared one bucket per cycle,
// with in_stall high until the last bucket is cleared; configuration writes are taken meanwhile
`default_nettype none
`include "bucket_mean_accumulator_macros.svh"
module bucket_mean_accumulator
  import bma_pkg::*;
#(
  parameter int NUM_BUCKETS = 4096,
  parameter int VALUE_BITS  = 16,
  parameter int COUNT_BITS  = 24
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_req_type,
  input  wire logic [BUCKET_W-1:0] in_bucket,
  input  wire logic [SAMPLE_W-1:0] in_sample_value,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [MEAN_W-1:0]        out_mean_fraction,
  output logic [STATUS_W-1:0]      out_status,
  output logic [BUCKET_W-1:0]      out_echo_bucket
);

  localparam int AW       = $clog2(NUM_BUCKETS);
  localparam int SUM_BITS = VALUE_BITS + COUNT_BITS;
  localparam int D_BITS   = COUNT_BITS + FS_W;
  localparam int REM_BITS = ((SUM_BITS > D_BITS) ? SUM_BITS : D_BITS) + 1;
  localparam int RAM_W    = SUM_BITS + COUNT_BITS;

  localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [AW-1:0]         CLR_LAST = AW'(NUM_BUCKETS - 1);

  // sequencer states
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DATA   = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [AW-1:0]         clr_r, clr_nxt;
  logic [FS_W-1:0]       fs_r;
  logic [BIU_W-1:0]      biu_r;

  logic                  req_r;
  logic [BUCKET_W-1:0]   bucket_r;
  logic [AW-1:0]         addr_r;
  logic [VALUE_BITS-1:0] val_r;
  logic                  oor_r;

  logic [D_BITS-1:0]     d_r, d_nxt;
  logic [REM_BITS-1:0]   rem_r, rem_nxt;
  logic [MEAN_W-1:0]     q_r, q_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [MEAN_W-1:0]     res_mean_r, res_mean_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [MEAN_W-1:0]     out_mean_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [BUCKET_W-1:0]   out_bucket_r;

  logic                  in_fire;
  logic                  in_oor;
  logic                  out_load;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [RAM_W-1:0]      ram_wdata;
  logic [RAM_W-1:0]      ram_rdata;
  logic [SUM_BITS-1:0]   rd_sum;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [FS_W-1:0]       fs_eff;
  logic [REM_BITS-1:0]   div_op;
  logic [REM_BITS:0]     trial;
  logic                  borrow;
  logic [REM_BITS-1:0]   rem_sel;
  logic [MEAN_W-1:0]     q_fin;

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_load = (state_r == ST_RESULT) && (!out_valid_r || !out_stall);

  // bucket range check against the register and the store depth
  assign in_oor = ({1'b0, in_bucket} >= biu_r) || (32'(in_bucket) >= NUM_BUCKETS);

  assign rd_sum = ram_rdata[RAM_W-1:COUNT_BITS];
  assign rd_cnt = ram_rdata[COUNT_BITS-1:0];
  assign fs_eff = (fs_r == '0) ? FS_W'(1) : fs_r;

  // sum and count store
  bma_ram #(
    .WIDTH(RAM_W),
    .DEPTH(NUM_BUCKETS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (in_fire),
    .raddr(AW'(in_bucket)),
    .rdata(ram_rdata)
  );

  // store write: clearing pass or accumulate update
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = {rd_sum + SUM_BITS'(val_r), rd_cnt + COUNT_BITS'(1)};
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if ((state_r == ST_DATA) && !oor_r && (req_r == REQ_ACC) &&
                 (rd_cnt != CNT_MAX)) begin
      ram_we = 1'b1;
    end
  end

  // shared compare-subtract unit: first step checks against twice the divisor
  assign div_op  = (step_r == '0) ? REM_BITS'({d_r, 1'b0}) : REM_BITS'(d_r);
  assign trial   = {1'b0, rem_r} - {1'b0, div_op};
  assign borrow  = trial[REM_BITS];
  assign rem_sel = borrow ? rem_r : trial[REM_BITS-1:0];
  assign q_fin   = {q_r[MEAN_W-2:0], ~borrow};

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    d_nxt          = d_r;
    rem_nxt        = rem_r;
    q_nxt          = q_r;
    step_nxt       = step_r;
    res_mean_nxt   = res_mean_r;
    res_status_nxt = res_status_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        res_mean_nxt = '0;
        state_nxt    = ST_RESULT;
        if (oor_r) begin
          res_status_nxt = STATUS_RANGE;
        end else if (req_r == REQ_ACC) begin
          res_status_nxt = (rd_cnt == CNT_MAX) ? STATUS_SAT : STATUS_OK;
        end else if (rd_cnt == '0) begin
          res_status_nxt = STATUS_EMPTY;
        end else begin
          res_status_nxt = (rd_cnt == CNT_MAX) ? STATUS_SAT : STATUS_OK;
          d_nxt          = D_BITS'(rd_cnt) * D_BITS'(fs_eff);
          rem_nxt        = REM_BITS'(rd_sum);
          q_nxt          = '0;
          step_nxt       = '0;
          state_nxt      = ST_DIV;
        end
      end
      ST_DIV: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == '0) begin
          // mean of two or more full scales saturates at once
          if (!borrow) begin
            res_mean_nxt = ONE_Q16;
            state_nxt    = ST_RESULT;
          end
        end else begin
          q_nxt   = q_fin;
          rem_nxt = {rem_sel[REM_BITS-2:0], 1'b0};
          if (step_r == STEP_W'(DIV_LAST)) begin
            res_mean_nxt = (q_fin > ONE_Q16) ? ONE_Q16 : q_fin;
            state_nxt    = ST_RESULT;
          end
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // output handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      fs_r        <= FS_RESET;
      biu_r       <= BIU_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && (cfg_index == CFG_FULL_SCALE)) begin
        fs_r <= cfg_wdata[FS_W-1:0];
      end
      if (cfg_we && (cfg_index == CFG_BUCKETS)) begin
        biu_r <= cfg_wdata[BIU_W-1:0];
      end
    end
  end

  // item, divider and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r    <= in_req_type;
      bucket_r <= in_bucket;
      addr_r   <= AW'(in_bucket);
      val_r    <= VALUE_BITS'(in_sample_value);
      oor_r    <= in_oor;
    end
    d_r          <= d_nxt;
    rem_r        <= rem_nxt;
    q_r          <= q_nxt;
    step_r       <= step_nxt;
    res_mean_r   <= res_mean_nxt;
    res_status_r <= res_status_nxt;
    if (out_load) begin
      out_mean_r   <= res_mean_r;
      out_status_r <= res_status_r;
      out_bucket_r <= bucket_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mean_fraction = out_mean_r;
  assign out_status        = out_status_r;
  assign out_echo_bucket   = out_bucket_r;

  // checks
  `BMA_ASSERT_NEXT(a_accept_reads, clk, rst_n, in_fire, state_r == ST_DATA, "accept did not start a read")
  `BMA_ASSERT_SAME(a_no_write_in_div, clk, rst_n, state_r == ST_DIV, !ram_we, "store written during divide")
  `BMA_ASSERT_SAME(a_mean_bound, clk, rst_n, out_valid, out_mean_fraction <= ONE_Q16, "mean above one")
  `BMA_ASSERT_SAME(a_empty_zero, clk, rst_n, out_valid && (out_status == STATUS_EMPTY), out_mean_fraction == '0, "empty bucket with nonzero mean")

endmodule
`default_nettype wire

>>> design/bma_ram.sv
// generic single write port ram with registered read
`default_nettype none
module bma_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
